/* rtl/lcpc_pkg.sv */
package lcpc_pkg;

  localparam int RAW_W        = 24;
  localparam int SUM_W        = 29;
  localparam int CNT_W        = 5;
  localparam int SAMPLE_LIMIT = 16;

  localparam int OFF_W    = 24;
  localparam int GAIN_W   = 21;
  localparam int TARE_W   = 24;
  localparam int UNIT_W   = 20;
  localparam int PIECE_W  = 6;
  localparam int REJECT_W = 20;

  localparam int DIFF_W   = 25;
  localparam int PROD_W   = DIFF_W + GAIN_W;
  localparam int SHIFT_W  = PROD_W - 16;
  localparam int WEIGHT_W = 26;
  localparam int NET_W    = 25;
  localparam int CAP_W    = PIECE_W + UNIT_W;

  // shared divider: dividend holds |sum| (up to 2^27) or net weight
  localparam int DIV_W  = 28;
  localparam int DVS_W  = UNIT_W;
  localparam int STEP_W = $clog2(DIV_W);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MG_PER_COUNT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARE_MG      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNIT_MG      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_COUNT    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_REJECT_MG    = 3'd6;

  localparam logic [CNT_W-1:0]           SAMPLE_COUNT_RST = 5'd12;
  localparam logic signed [OFF_W-1:0]    ZERO_OFFSET_RST  = -24'sd2760;
  localparam logic signed [GAIN_W-1:0]   MG_PER_COUNT_RST = -21'sd87646;
  localparam logic [TARE_W-1:0]          TARE_MG_RST      = 24'd70000;
  localparam logic [UNIT_W-1:0]          UNIT_MG_RST      = 20'd35000;
  localparam logic [PIECE_W-1:0]         MAX_COUNT_RST    = 6'd50;
  localparam logic [REJECT_W-1:0]        REJECT_MG_RST    = 20'd15000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_DIFF,
    ST_MUL,
    ST_WEIGHT,
    ST_NET,
    ST_UNIT_START,
    ST_UNIT_WAIT,
    ST_PICK,
    ST_OUT
  } state_t;

endpackage

/* rtl/lcpc_div.sv */
module lcpc_div import lcpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic [DIV_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    trial   = shifted - {1'b0, dvs};
    fits    = !trial[DVS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* rtl/load_cell_piece_counter_top.sv */
// A word that does not close a group leaves the sequencer idle, so s_tready stays high.
// A word that closes a group raises m_tvalid after two passes of the shared divider
// (start, one step per quotient bit, done) and 6 single steps: DIFF, MUL, WEIGHT, NET, PICK, OUT.
// Throughput: one word per cycle inside a group; the closing word holds the input off
// until its result is loaded, which waits while the previous result is still not taken.
// Reset (rst, synchronous, active high): registers return to their defaults,
// sums, counters and kept piece count clear, no result is pending.
module load_cell_piece_counter_top import lcpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [23:0] raw_word
  input  logic                  s_tuser,   // [0] timed_out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // weight_mg, net_mg, piece_count, match_error_mg, pad
  output logic                  m_tuser,   // [0] no_valid_sample
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT_W-1:0]           sample_count;
  logic signed [OFF_W-1:0]    zero_offset;
  logic signed [GAIN_W-1:0]   mg_per_count_q16;
  logic [TARE_W-1:0]          tare_mg;
  logic [UNIT_W-1:0]          unit_mg;
  logic [PIECE_W-1:0]         max_count;
  logic [REJECT_W-1:0]        reject_mg;

  state_t state, state_next;

  logic signed [SUM_W-1:0]  sample_sum;
  logic [CNT_W-1:0]         valid_count;
  logic [CNT_W-1:0]         samples_seen;
  logic [PIECE_W-1:0]       last_count;

  logic                     avg_neg;
  logic                     none;
  logic signed [RAW_W-1:0]  avg;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] product;
  logic signed [WEIGHT_W-1:0] weight;
  logic [NET_W-1:0]         net;
  logic [CAP_W-1:0]         cap_mg;
  logic [PIECE_W-1:0]       best;
  logic [NET_W-1:0]         err;

  logic                     out_valid;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic [NET_W-1:0]         out_net;
  logic [PIECE_W-1:0]       out_count;
  logic [NET_W-1:0]         out_err;
  logic                     out_none;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [DVS_W-1:0]         div_rem;

  logic                     in_fire;
  logic                     sample_ok;
  logic signed [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]         seen_inc;
  logic [CNT_W-1:0]         n_eff;
  logic                     group_end;
  logic [SUM_W-1:0]         sum_mag;
  logic [DIV_W-1:0]         avg_mag;
  logic signed [SHIFT_W-1:0] wshift;
  logic signed [WEIGHT_W-1:0] wsat;
  logic signed [WEIGHT_W:0] net_wide;
  logic [UNIT_W-1:0]        hi_err;
  logic [PIECE_W-1:0]       best_pick;
  logic [NET_W-1:0]         err_pick;
  logic [PIECE_W-1:0]       count_new;
  logic                     out_free;

  lcpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= SAMPLE_COUNT_RST;
      zero_offset      <= ZERO_OFFSET_RST;
      mg_per_count_q16 <= MG_PER_COUNT_RST;
      tare_mg          <= TARE_MG_RST;
      unit_mg          <= UNIT_MG_RST;
      max_count        <= MAX_COUNT_RST;
      reject_mg        <= REJECT_MG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_SAMPLE_COUNT: sample_count     <= cfg_data[CNT_W-1:0];
        REG_ZERO_OFFSET:  zero_offset      <= signed'(cfg_data[OFF_W-1:0]);
        REG_MG_PER_COUNT: mg_per_count_q16 <= signed'(cfg_data[GAIN_W-1:0]);
        REG_TARE_MG:      tare_mg          <= cfg_data[TARE_W-1:0];
        REG_UNIT_MG:      unit_mg          <= cfg_data[UNIT_W-1:0];
        REG_MAX_COUNT:    max_count        <= cfg_data[PIECE_W-1:0];
        REG_REJECT_MG:    reject_mg        <= cfg_data[REJECT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sample_ok = !s_tuser && (s_tdata[RAW_W-1:0] != '0);
    sum_add   = sample_sum + SUM_W'(signed'(s_tdata[RAW_W-1:0]));
    seen_inc  = samples_seen + 1'b1;
    priority if (sample_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (sample_count > CNT_W'(SAMPLE_LIMIT)) begin
      n_eff = CNT_W'(SAMPLE_LIMIT);
    end else begin
      n_eff = sample_count;
    end
    group_end = (seen_inc >= n_eff);
    sum_mag   = sample_sum[SUM_W-1] ? (~sample_sum + 1'b1) : sample_sum;
    avg_mag   = avg_neg ? (~div_quo + 1'b1) : div_quo;
    wshift    = product[PROD_W-1:16];
    // hold the weight within 26 bits
    if (wshift[SHIFT_W-1:WEIGHT_W-1] == '0 || wshift[SHIFT_W-1:WEIGHT_W-1] == '1) begin
      wsat = wshift[WEIGHT_W-1:0];
    end else if (wshift[SHIFT_W-1]) begin
      wsat = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      wsat = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
    net_wide = {weight[WEIGHT_W-1], weight} - (WEIGHT_W+1)'(tare_mg);
    // nearest count from quotient and remainder, capped at max_count; ties go to the lower count
    hi_err = unit_mg - div_rem;
    priority if (unit_mg == '0) begin
      best_pick = '0;
      err_pick  = net;
    end else if (div_quo >= DIV_W'(max_count)) begin
      best_pick = max_count;
      err_pick  = net - cap_mg[NET_W-1:0];
    end else if (div_rem <= hi_err) begin
      best_pick = div_quo[PIECE_W-1:0];
      err_pick  = NET_W'(div_rem);
    end else begin
      best_pick = div_quo[PIECE_W-1:0] + 1'b1;
      err_pick  = NET_W'(hi_err);
    end
    priority if (err <= NET_W'(reject_mg)) begin
      count_new = best;
    end else if (best > last_count) begin
      count_new = last_count + 1'b1;
    end else if (best < last_count) begin
      count_new = last_count - 1'b1;
    end else begin
      count_new = last_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = sum_mag[DIV_W-1:0];
    div_divisor  = DVS_W'(valid_count);
    unique case (state)
      ST_IDLE:       if (in_fire && group_end) state_next = ST_AVG_START;
      ST_AVG_START: begin
        div_start  = 1'b1;
        state_next = ST_AVG_WAIT;
      end
      ST_AVG_WAIT:   if (div_done) state_next = ST_DIFF;
      ST_DIFF:       state_next = ST_MUL;
      ST_MUL:        state_next = ST_WEIGHT;
      ST_WEIGHT:     state_next = ST_NET;
      ST_NET:        state_next = ST_UNIT_START;
      ST_UNIT_START: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(net);
        div_divisor  = unit_mg;
        state_next   = ST_UNIT_WAIT;
      end
      ST_UNIT_WAIT:  if (div_done) state_next = ST_PICK;
      ST_PICK:       state_next = ST_OUT;
      ST_OUT:        if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      valid_count  <= '0;
      samples_seen <= '0;
      last_count   <= '0;
    end else begin
      if (in_fire) begin
        samples_seen <= seen_inc;
        if (sample_ok) begin
          sample_sum  <= sum_add;
          valid_count <= valid_count + 1'b1;
        end
      end
      // divider has latched the sum: clear for the next group
      if (state == ST_AVG_START) begin
        sample_sum   <= '0;
        valid_count  <= '0;
        samples_seen <= '0;
      end
      if (state == ST_OUT && out_free) begin
        last_count <= count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_AVG_START: begin
        avg_neg <= sample_sum[SUM_W-1];
        none    <= (valid_count == '0);
      end
      ST_AVG_WAIT:  avg     <= none ? '0 : signed'(avg_mag[RAW_W-1:0]);
      ST_DIFF:      diff    <= DIFF_W'(avg) - DIFF_W'(zero_offset);
      ST_MUL:       product <= PROD_W'(diff) * PROD_W'(mg_per_count_q16);
      ST_WEIGHT: begin
        weight <= wsat;
        cap_mg <= CAP_W'(max_count) * CAP_W'(unit_mg);
      end
      ST_NET:       net     <= net_wide[WEIGHT_W] ? '0 : net_wide[NET_W-1:0];
      ST_PICK: begin
        best <= best_pick;
        err  <= err_pick;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_weight <= weight;
      out_net    <= net;
      out_count  <= count_new;
      out_err    <= err;
      out_none   <= none;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_none;
  assign m_tdata  = {6'b0, out_err, out_count, out_net, out_weight};

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_AVG_WAIT || state == ST_UNIT_WAIT))
    else $error("divider finished outside a wait state");

  // the closing word of a full group leaves the counter at the limit for one cycle
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    samples_seen <= CNT_W'(SAMPLE_LIMIT))
    else $error("sample counter passed the group limit");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !s_tvalid) |=> state == ST_IDLE)
    else $error("sequencer left idle without a word");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !m_tready) |=> state == ST_OUT)
    else $error("result loaded over a pending word");

endmodule
